// File: hdl/u16u8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// No dependencies; imported by every module of the block.
package u16u8_pkg;

    // Code unit and code point widths
    localparam int UNIT_W = 16;
    localparam int CP_W   = 21;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic REG_DETECT_BOM = 1'b0;
    localparam logic REG_SWAP_BYTES = 1'b1;

    // Status codes carried with each result
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_BOM   = 2'd1;
    localparam logic [1:0] ST_BAD_PAIR = 2'd2;

    // Special code units and ranges
    localparam logic [15:0] BOM_NATIVE  = 16'hFEFF;
    localparam logic [15:0] BOM_SWAPPED = 16'hFFFE;
    localparam logic [15:0] HIGH_FIRST  = 16'hD800;
    localparam logic [15:0] HIGH_LAST   = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST   = 16'hDC00;
    localparam logic [15:0] LOW_LAST    = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    // UTF-8 length limits
    localparam logic [20:0] MAX_1BYTE = 21'h7F;
    localparam logic [20:0] MAX_2BYTE = 21'h7FF;
    localparam logic [20:0] MAX_3BYTE = 21'hFFFF;

    // UTF-8 lead and continuation markers
    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    // Kind of work handed from front to back
    typedef enum logic [1:0] {
        JOB_CHAR,
        JOB_ERR,
        JOB_TERM
    } t_job_kind;

    typedef struct packed {
        t_job_kind       kind;
        logic [CP_W-1:0] cp;
        logic [1:0]      status;
    } t_job;

    // Configuration register values
    typedef struct packed {
        logic detect_bom;
        logic swap_bytes;
    } t_cfg;

endpackage

// File: hdl/u16u8_front.sv
// Front end: accepts code units, tracks string state and classifies each
// unit into a job for the back end. Depends on u16u8_pkg.
module u16u8_front
    import u16u8_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    input  logic [UNIT_W-1:0] i_code_unit,
    output logic              o_ready,
    input  logic              i_q_full,
    output logic              o_push,
    output t_job              o_job
);

    logic       r_at_start, n_at_start;
    logic       r_swap_active, n_swap_active;
    logic       r_high_pending, n_high_pending;
    logic [9:0] r_high_bits, n_high_bits;
    logic       r_discarding, n_discarding;

    logic              w_accept;
    logic              w_swap;
    logic [UNIT_W-1:0] w_c;
    logic [CP_W-1:0]   w_pair_cp;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;

    // Byte order in force for this unit
    assign w_swap = r_at_start ? i_cfg.swap_bytes : r_swap_active;
    assign w_c    = w_swap ? {i_code_unit[7:0], i_code_unit[15:8]} : i_code_unit;

    // Code point of a surrogate pair
    assign w_pair_cp = SUPP_BASE + {1'b0, r_high_bits, w_c[9:0]};

    // Classification and next state
    always_comb begin
        n_at_start     = r_at_start;
        n_swap_active  = r_swap_active;
        n_high_pending = r_high_pending;
        n_high_bits    = r_high_bits;
        n_discarding   = r_discarding;
        o_push         = 1'b0;
        o_job.kind     = JOB_CHAR;
        o_job.cp       = {5'd0, w_c};
        o_job.status   = ST_OK;

        if (w_accept) begin
            if (i_code_unit == '0) begin
                // terminator always yields one result and restarts
                o_push       = 1'b1;
                o_job.kind   = JOB_TERM;
                o_job.cp     = '0;
                if (!r_discarding) begin
                    if (r_high_pending) begin
                        o_job.status = ST_BAD_PAIR;
                    end else if (r_at_start && i_cfg.detect_bom) begin
                        o_job.status = ST_NO_BOM;
                    end
                end
                n_at_start     = 1'b1;
                n_high_pending = 1'b0;
                n_high_bits    = '0;
                n_discarding   = 1'b0;
            end else if (!r_discarding) begin
                if (r_at_start && i_cfg.detect_bom) begin
                    n_at_start = 1'b0;
                    if (i_code_unit == BOM_NATIVE) begin
                        n_swap_active = 1'b0;
                    end else if (i_code_unit == BOM_SWAPPED) begin
                        n_swap_active = 1'b1;
                    end else begin
                        o_push         = 1'b1;
                        o_job.kind     = JOB_ERR;
                        o_job.status   = ST_NO_BOM;
                        n_discarding   = 1'b1;
                        n_high_pending = 1'b0;
                    end
                end else begin
                    if (r_at_start) begin
                        n_at_start    = 1'b0;
                        n_swap_active = i_cfg.swap_bytes;
                    end
                    if (r_high_pending) begin
                        o_push = 1'b1;
                        if (w_c < LOW_FIRST || w_c > LOW_LAST) begin
                            o_job.kind     = JOB_ERR;
                            o_job.status   = ST_BAD_PAIR;
                            n_discarding   = 1'b1;
                        end else begin
                            o_job.cp = w_pair_cp;
                        end
                        n_high_pending = 1'b0;
                    end else if (w_c >= HIGH_FIRST && w_c <= HIGH_LAST) begin
                        n_high_pending = 1'b1;
                        n_high_bits    = w_c[9:0];
                    end else if (w_c >= LOW_FIRST && w_c <= LOW_LAST) begin
                        o_push         = 1'b1;
                        o_job.kind     = JOB_ERR;
                        o_job.status   = ST_BAD_PAIR;
                        n_discarding   = 1'b1;
                    end else begin
                        o_push = 1'b1;
                    end
                end
            end
        end
    end

    // String state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start     <= 1'b1;
            r_swap_active  <= 1'b0;
            r_high_pending <= 1'b0;
            r_high_bits    <= '0;
            r_discarding   <= 1'b0;
        end else begin
            r_at_start     <= n_at_start;
            r_swap_active  <= n_swap_active;
            r_high_pending <= n_high_pending;
            r_high_bits    <= n_high_bits;
            r_discarding   <= n_discarding;
        end
    end

endmodule

// File: hdl/u16u8_queue.sv
// Two-entry job queue between front and back end.
// Depends on u16u8_pkg for the job type.
module u16u8_queue
    import u16u8_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_job   = r_mem[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// File: hdl/u16u8_back.sv
// Back end: turns queued jobs into UTF-8 bytes, one per cycle while not
// stalled by i_ready, into an output register. Depends on u16u8_pkg.
module u16u8_back
    import u16u8_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_utf8_byte,
    output logic       o_last_of_run,
    output logic       o_end_of_string,
    output logic [1:0] o_status
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_eos;
    logic [1:0] r_status;

    logic       w_load;
    logic [1:0] w_last_idx;
    logic [1:0] w_pos;
    logic       w_last;
    logic [7:0] w_lead;
    logic [5:0] w_cont;
    logic [7:0] w_byte;

    // Byte count minus one of the current job
    always_comb begin
        if (i_job.kind != JOB_CHAR || i_job.cp <= MAX_1BYTE) begin
            w_last_idx = 2'd0;
        end else if (i_job.cp <= MAX_2BYTE) begin
            w_last_idx = 2'd1;
        end else if (i_job.cp <= MAX_3BYTE) begin
            w_last_idx = 2'd2;
        end else begin
            w_last_idx = 2'd3;
        end
    end

    assign w_last = r_idx == w_last_idx;
    assign w_pos  = w_last_idx - r_idx;

    // Lead byte by length
    always_comb begin
        case (w_last_idx)
            2'd0:    w_lead = {1'b0, i_job.cp[6:0]};
            2'd1:    w_lead = LEAD2 | {3'd0, i_job.cp[10:6]};
            2'd2:    w_lead = LEAD3 | {4'd0, i_job.cp[15:12]};
            2'd3:    w_lead = LEAD4 | {5'd0, i_job.cp[20:18]};
            default: w_lead = '0;
        endcase
    end

    // Six payload bits of a continuation byte, by bytes still to follow
    always_comb begin
        case (w_pos)
            2'd0:    w_cont = i_job.cp[5:0];
            2'd1:    w_cont = i_job.cp[11:6];
            2'd2:    w_cont = i_job.cp[17:12];
            default: w_cont = '0;
        endcase
    end

    always_comb begin
        if (i_job.kind != JOB_CHAR) begin
            w_byte = '0;
        end else if (r_idx == 2'd0) begin
            w_byte = w_lead;
        end else begin
            w_byte = CONT | {2'd0, w_cont};
        end
    end

    assign w_load = i_q_valid && (!r_valid || i_ready);
    assign o_pop  = w_load && w_last;

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte   <= w_byte;
            r_last   <= w_last;
            r_eos    <= i_job.kind == JOB_TERM;
            r_status <= i_job.status;
        end
    end

    // Byte index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_utf8_byte     = r_byte;
    assign o_last_of_run   = r_last;
    assign o_end_of_string = r_eos;
    assign o_status        = r_status;

endmodule

// File: hdl/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder top level: configuration registers, front end,
// job queue and back end. Depends on u16u8_pkg and the u16u8_* modules.
//
// Usage:
//   Input channel (i_valid/o_ready) takes one 16-bit code unit per item.
//   Output channel (o_valid/i_ready) gives one UTF-8 byte per item with
//   last_of_run on the final byte of a unit, end_of_string on the 0x00
//   terminator and a status code (0 ok, 1 missing mark, 2 bad pair).
//   Registers over APB: detect_bom at 0x0, swap_bytes at 0x4; write them
//   only while the block is idle. Byte order is latched at string start.
// Path: a unit's job passes the job queue, its bytes the output register. The
//   back-end serializer sets throughput at one byte per cycle while i_ready
//   is high: a unit gives 1 to 4 bytes (4 for a surrogate pair), units that
//   give no bytes (marks, high surrogates, dropped units) cost none there.
//   Units are taken every cycle while the two-entry job queue has room.
// Reset: synchronous, active low; clears string state, queue and output
//   valid, and both registers go to 0.
// Stall: when i_ready is low the output byte holds; the queue fills and
//   then o_ready drops until the back end drains.
module utf16_to_utf8_transcoder
    import u16u8_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [UNIT_W-1:0] i_code_unit,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_utf8_byte,
    output logic              o_last_of_run,
    output logic              o_end_of_string,
    output logic [1:0]        o_status
);

    t_cfg r_cfg;
    logic w_cfg_wr;
    logic w_q_full;
    logic w_push;
    t_job w_push_job;
    logic w_q_valid;
    logic w_pop;
    t_job w_head_job;

    // Configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_DETECT_BOM) begin
                r_cfg.detect_bom <= pwdata[0];
            end else begin
                r_cfg.swap_bytes <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_SWAP_BYTES) begin
            prdata = {31'd0, r_cfg.swap_bytes};
        end else begin
            prdata = {31'd0, r_cfg.detect_bom};
        end
    end

    u16u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .i_code_unit (i_code_unit),
        .o_ready     (o_ready),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    u16u8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_job   (w_head_job)
    );

    u16u8_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_job           (w_head_job),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_utf8_byte     (o_utf8_byte),
        .o_last_of_run   (o_last_of_run),
        .o_end_of_string (o_end_of_string),
        .o_status        (o_status)
    );

endmodule

// File: bench/u16u8_stream_checker.sv
// Stream checker for the UTF-16 to UTF-8 transcoder: tracks the APB register
// writes, predicts the bytes of every accepted code unit and compares them.
// Depends on u16u8_pkg for status codes, special units and UTF-8 markers.
`timescale 1ns / 100ps

module u16u8_stream_checker
    import u16u8_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB register port, observed only
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    // code unit channel
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_in_unit,
    // byte channel
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_byte,
    input  logic        i_out_last,
    input  logic        i_out_eos,
    input  logic [1:0]  i_out_status,
    // to the bench top
    output int          o_pending,
    output int          o_fail_count
);

    typedef struct packed {
        logic [7:0] utf8;
        logic       last_unit;
        logic       eos;
        logic [1:0] status;
    } t_utf8_out;

    t_utf8_out expected_bytes[$];

    // Shadow of the registers and of the string state
    t_cfg       cfg;
    logic       at_start;
    logic       swap_on;
    logic       hi_pend;
    logic [9:0] hi_bits;
    logic       dropping;
    int         n_mismatch;

    assign o_fail_count = n_mismatch;

    // One line per mismatch, and count it
    task automatic report_mismatch(input string what, input int got, input int want);
        n_mismatch++;
        $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic add_byte(input logic [7:0] b, input logic lst, input logic eos,
                            input logic [1:0] st);
        t_utf8_out r;
        r.utf8      = b;
        r.last_unit = lst;
        r.eos       = eos;
        r.status    = st;
        expected_bytes.push_back(r);
    endtask

    // Error result: status only, then drop units until the terminator
    task automatic flag_error(input logic [1:0] st);
        dropping = 1'b1;
        hi_pend  = 1'b0;
        add_byte(8'h00, 1'b1, 1'b0, st);
    endtask

    // UTF-8 encoding, lead byte first
    task automatic emit_utf8(input logic [20:0] cp);
        if (cp <= MAX_1BYTE) begin
            add_byte(cp[7:0], 1'b1, 1'b0, ST_OK);
        end else if (cp <= MAX_2BYTE) begin
            add_byte(LEAD2 | {3'b0, cp[10:6]}, 1'b0, 1'b0, ST_OK);
            add_byte(CONT | {2'b0, cp[5:0]}, 1'b1, 1'b0, ST_OK);
        end else if (cp <= MAX_3BYTE) begin
            add_byte(LEAD3 | {4'b0, cp[15:12]}, 1'b0, 1'b0, ST_OK);
            add_byte(CONT | {2'b0, cp[11:6]}, 1'b0, 1'b0, ST_OK);
            add_byte(CONT | {2'b0, cp[5:0]}, 1'b1, 1'b0, ST_OK);
        end else begin
            add_byte(LEAD4 | {5'b0, cp[20:18]}, 1'b0, 1'b0, ST_OK);
            add_byte(CONT | {2'b0, cp[17:12]}, 1'b0, 1'b0, ST_OK);
            add_byte(CONT | {2'b0, cp[11:6]}, 1'b0, 1'b0, ST_OK);
            add_byte(CONT | {2'b0, cp[5:0]}, 1'b1, 1'b0, ST_OK);
        end
    endtask

    // Expected bytes of one accepted code unit
    task automatic transcode_unit(input logic [15:0] raw);
        logic [15:0] cu;
        logic [1:0]  st;
        logic        go_on;
        go_on = 1'b1;
        if (raw == 16'h0000) begin
            // terminator; a pending high or a missing mark shows in its status
            st = ST_OK;
            if (!dropping) begin
                if (hi_pend)
                    st = ST_BAD_PAIR;
                else if (at_start && cfg.detect_bom)
                    st = ST_NO_BOM;
            end
            at_start = 1'b1;
            hi_pend  = 1'b0;
            hi_bits  = '0;
            dropping = 1'b0;
            add_byte(8'h00, 1'b1, 1'b1, st);
            go_on = 1'b0;
        end else if (dropping) begin
            go_on = 1'b0;
        end else if (at_start) begin
            // byte order is latched here
            at_start = 1'b0;
            if (cfg.detect_bom) begin
                go_on = 1'b0;
                if (raw == BOM_NATIVE)
                    swap_on = 1'b0;
                else if (raw == BOM_SWAPPED)
                    swap_on = 1'b1;
                else
                    flag_error(ST_NO_BOM);
            end else begin
                swap_on = cfg.swap_bytes;
            end
        end

        if (go_on) begin
            cu = swap_on ? {raw[7:0], raw[15:8]} : raw;
            if (hi_pend) begin
                if (cu < LOW_FIRST || cu > LOW_LAST) begin
                    flag_error(ST_BAD_PAIR);
                end else begin
                    hi_pend = 1'b0;
                    emit_utf8(SUPP_BASE + {1'b0, hi_bits, cu[9:0]});
                end
            end else if (cu >= HIGH_FIRST && cu <= HIGH_LAST) begin
                hi_pend = 1'b1;
                hi_bits = cu[9:0];
            end else if (cu >= LOW_FIRST && cu <= LOW_LAST) begin
                flag_error(ST_BAD_PAIR);
            end else begin
                emit_utf8({5'b0, cu});
            end
        end
    endtask

    // Compare one accepted byte with the oldest expectation
    task automatic check_byte();
        t_utf8_out want;
        if (expected_bytes.size() == 0) begin
            report_mismatch("byte with nothing expected", int'(i_out_byte), 0);
        end else begin
            want = expected_bytes.pop_front();
            if (i_out_byte !== want.utf8)
                report_mismatch("utf8_byte", int'(i_out_byte), int'(want.utf8));
            if (i_out_last !== want.last_unit)
                report_mismatch("last_of_run", int'(i_out_last), int'(want.last_unit));
            if (i_out_eos !== want.eos)
                report_mismatch("end_of_string", int'(i_out_eos), int'(want.eos));
            if (i_out_status !== want.status)
                report_mismatch("status", int'(i_out_status), int'(want.status));
        end
    endtask

    // Bytes are checked before the unit of the same edge is predicted:
    // a unit never yields a byte in the cycle it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg      = '0;
            at_start = 1'b1;
            swap_on  = 1'b0;
            hi_pend  = 1'b0;
            hi_bits  = '0;
            dropping = 1'b0;
            expected_bytes.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    REG_DETECT_BOM: cfg.detect_bom = pwdata[0];
                    REG_SWAP_BYTES: cfg.swap_bytes = pwdata[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready)
                check_byte();
            if (i_in_valid && i_in_ready)
                transcode_unit(i_in_unit);
        end
        o_pending <= expected_bytes.size();
    end

    initial n_mismatch = 0;

endmodule

// File: bench/utf16_to_utf8_transcoder_tb.sv
// Bench top for the UTF-16 to UTF-8 transcoder: clock, reset, register
// writes, code unit and byte traffic, verdict. Depends on u16u8_pkg, the
// transcoder and u16u8_stream_checker.
`timescale 1ns / 100ps

module utf16_to_utf8_transcoder_tb
    import u16u8_pkg::*;
();

    localparam int  DRAIN_CYCLES = 20;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  PHASE_UNITS  = 16;
    localparam real TIMEOUT_NS   = 1000000.0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [15:0] i_code_unit = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_utf8_byte;
    logic        o_last_of_run;
    logic        o_end_of_string;
    logic [1:0]  o_status;

    int   pending;
    int   fail_count;
    int   n_units = 0;
    int   rx_gap = 0;
    logic no_idle = 1'b0;
    logic hold_req = 1'b0;
    logic cfg_detect = 1'b0;
    logic cfg_swap = 1'b0;

    utf16_to_utf8_transcoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_code_unit     (i_code_unit),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_utf8_byte     (o_utf8_byte),
        .o_last_of_run   (o_last_of_run),
        .o_end_of_string (o_end_of_string),
        .o_status        (o_status)
    );

    u16u8_stream_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_unit    (i_code_unit),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_byte   (o_utf8_byte),
        .i_out_last   (o_last_of_run),
        .i_out_eos    (o_end_of_string),
        .i_out_status (o_status),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #1 i_clk = ~i_clk;

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Offer one item and hold it until taken; returns on the accepting edge
    task automatic send_unit(input logic [15:0] u);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_code_unit <= u;
        do @(posedge i_clk); while (!o_ready);
        n_units++;
    endtask

    task automatic send_ordered(input logic [15:0] c, input logic order);
        send_unit(order ? {c[7:0], c[15:8]} : c);
    endtask

    // Called on an accepting edge: drop valid, wait for every byte, then settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic wr_reg(input logic idx, input logic val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'b0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_DETECT_BOM)
            cfg_detect = val;
        else
            cfg_swap = val;
    endtask

    // One string and its terminator: either well formed (optional mark, then
    // characters of every length and surrogate pairs) or raw noise
    task automatic send_string(input logic noisy);
        int          n;
        int          kind;
        logic        order;
        logic [15:0] c;
        if (noisy) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                if ($urandom_range(0, 2) == 0)
                    send_unit(16'($urandom_range(HIGH_FIRST, LOW_LAST)));
                else
                    send_unit(16'($urandom_range(1, 16'hFFFF)));
            end
        end else begin
            if (cfg_detect) begin
                order = 1'($urandom_range(0, 1));
                send_unit(order ? BOM_SWAPPED : BOM_NATIVE);
            end else begin
                order = cfg_swap;
            end
            n = $urandom_range(1, 5);
            repeat (n) begin
                kind = $urandom_range(0, 4);
                case (kind)
                    0: c = 16'($urandom_range(1, 16'h007F));
                    1: c = 16'($urandom_range(16'h0080, 16'h07FF));
                    2: c = 16'($urandom_range(16'h0800, 16'hD7FF));
                    3: c = 16'($urandom_range(16'hE000, 16'hFFFF));
                    default: begin
                        send_ordered(16'($urandom_range(HIGH_FIRST, HIGH_LAST)), order);
                        c = 16'($urandom_range(LOW_FIRST, LOW_LAST));
                    end
                endcase
                send_ordered(c, order);
            end
        end
        send_unit(16'h0000);
    endtask

    // Byte receiver: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (no_idle || rx_gap == 0) begin
                i_ready <= 1'b1;
                rx_gap = pick_gap();
            end else begin
                i_ready <= 1'b0;
                rx_gap--;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int phase_start;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty string, length boundaries, smallest and largest pair
        send_unit(16'h0000);
        send_unit(16'h0001);
        send_unit(16'h007F);
        send_unit(16'h0080);
        send_unit(16'h07FF);
        send_unit(16'h0800);
        send_unit(16'hFFFF);
        send_unit(16'hD800);
        send_unit(16'hDC00);
        send_unit(16'hDBFF);
        send_unit(16'hDFFF);
        send_unit(16'h0000);
        // low surrogate first, then a dropped unit
        send_unit(16'hDC00);
        send_unit(16'h0041);
        send_unit(16'h0000);
        // high surrogate not followed by a low one
        send_unit(16'hD800);
        send_unit(16'h0041);
        send_unit(16'h0000);
        // high surrogate still pending at the terminator
        send_unit(16'hD800);
        send_unit(16'h0000);
        // swap written mid-string only applies from the next string
        send_unit(16'h0041);
        wait_idle();
        wr_reg(REG_SWAP_BYTES, 1'b1);
        send_unit(16'h4100);
        send_unit(16'h0000);
        // mark detection: empty string, missing mark, swapped and native mark
        wait_idle();
        wr_reg(REG_DETECT_BOM, 1'b1);
        send_unit(16'h0000);
        send_unit(16'h0041);
        send_unit(16'h0000);
        send_unit(BOM_SWAPPED);
        send_unit(16'h4100);
        send_unit(16'h0000);
        send_unit(BOM_NATIVE);
        send_unit(16'h0000);

        // Random strings over every register setting
        for (int p = 0; p < 5; p++) begin
            wait_idle();
            wr_reg(REG_DETECT_BOM, (p == 4) ? 1'($urandom_range(0, 1)) : p[1]);
            wr_reg(REG_SWAP_BYTES, (p == 4) ? 1'($urandom_range(0, 1)) : p[0]);
            no_idle = (p == 2);
            if (p == 1)
                hold_req = 1'b1;
            phase_start = n_units;
            while (n_units - phase_start < PHASE_UNITS)
                send_string($urandom_range(0, 4) == 0);
        end
        no_idle = 1'b0;
        wait_idle();

        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: files.f
hdl/u16u8_pkg.sv
hdl/u16u8_front.sv
hdl/u16u8_queue.sv
hdl/u16u8_back.sv
hdl/utf16_to_utf8_transcoder.sv
bench/u16u8_stream_checker.sv
bench/utf16_to_utf8_transcoder_tb.sv
